/* rtl/otdtb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package otdtb_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int TIMER_ID_W  = 3;
    localparam int TIME_W      = 32;
    localparam int SLOT_W      = 4;

    localparam logic [SLOT_W-1:0] MASK_RESET = 4'hF;

    // Input command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Result event codes.
    localparam logic EVT_STARTED = 1'b0;
    localparam logic EVT_EXPIRED = 1'b1;

    typedef struct packed {
        logic load_item;
        logic do_start;
        logic scan_step;
        logic emit_expiry;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cmd_is_start;
        logic item_flow;
        logic scan_last;
        logic hits_any;
        logic hits_last;
    } ctrl_sts_t;

endpackage

`default_nettype wire

/* rtl/otdtb_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface otdtb_in_if import otdtb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [TIMER_ID_W-1:0] timer_id;
    logic [TIME_W-1:0]     delay_ticks;
    logic                  notify_mode;

    modport source (output valid, command, timer_id, delay_ticks, notify_mode,
                    input ready);
    modport sink   (input valid, command, timer_id, delay_ticks, notify_mode,
                    output ready);
endinterface

interface otdtb_out_if import otdtb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  event_kind;
    logic [TIMER_ID_W-1:0] timer_number;
    logic                  uses_flow;
    logic [SLOT_W-1:0]     flow_slot;
    logic                  last_of_run;

    modport source (output valid, event_kind, timer_number, uses_flow, flow_slot,
                    last_of_run, input ready);
    modport sink   (input valid, event_kind, timer_number, uses_flow, flow_slot,
                    last_of_run, output ready);
endinterface

interface otdtb_cfg_if import otdtb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] flow_slot_mask;

    modport source (output valid, flow_slot_mask, input ready);
    modport sink   (input valid, flow_slot_mask, output ready);
endinterface

`default_nettype wire

/* rtl/otdtb_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module otdtb_datapath import otdtb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_cmd_t             ctl,
    output ctrl_sts_t                  sts,
    input  wire logic                  cfg_we,
    input  wire logic [SLOT_W-1:0]     cfg_mask,
    input  wire logic                  in_command,
    input  wire logic [TIMER_ID_W-1:0] in_timer_id,
    input  wire logic [TIME_W-1:0]     in_delay_ticks,
    input  wire logic                  in_notify_mode,
    output logic                       out_event_kind,
    output logic [TIMER_ID_W-1:0]      out_timer_number,
    output logic                       out_uses_flow,
    output logic [SLOT_W-1:0]          out_flow_slot,
    output logic                       out_last_of_run
);

    logic [TIME_W-1:0]      time_reg;
    logic [SLOT_W-1:0]      mask_reg;
    logic [SLOT_W-1:0]      ring_reg;
    logic [TIMER_COUNT-1:0] armed_reg;
    logic [TIMER_COUNT-1:0] hit_reg;
    logic [TIMER_ID_W-1:0]  scan_idx_reg;

    logic [TIMER_ID_W-1:0]  item_id_reg;
    logic [TIME_W-1:0]      item_delay_reg;
    logic                   item_mode_reg;

    logic [TIME_W-1:0]      deadline_mem [TIMER_COUNT];
    logic                   flow_mem     [TIMER_COUNT];
    logic [SLOT_W-1:0]      slot_mem     [TIMER_COUNT];

    logic                   scan_hit;
    logic [TIMER_ID_W-1:0]  first_hit;
    logic [TIMER_COUNT-1:0] hit_rest;
    logic [SLOT_W-1:0]      ring_next;

    // The single comparator of the bank, shared by all timers over the scan.
    assign scan_hit = armed_reg[scan_idx_reg] && (deadline_mem[scan_idx_reg] <= time_reg);

    // The sum wraps within the slot width; the mask then clears the slot bits it does not enable.
    assign ring_next = (ring_reg + 1'b1) & mask_reg;

    always_comb
    begin
        first_hit = '0;
        for (int i = TIMER_COUNT - 1; i >= 0; i--)
        begin
            if (hit_reg[i])
            begin
                first_hit = TIMER_ID_W'(i);
            end
        end
    end

    assign hit_rest = hit_reg & (hit_reg - 1'b1);

    // The controller routes a new item on the command still on the input.
    assign sts.cmd_is_start  = (in_command == CMD_START);
    assign sts.item_flow     = item_mode_reg;
    assign sts.scan_last     = (scan_idx_reg == TIMER_ID_W'(TIMER_COUNT - 1));
    assign sts.hits_any      = |hit_reg;
    assign sts.hits_last     = ~|hit_rest;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            mask_reg     <= MASK_RESET;
            ring_reg     <= '0;
            armed_reg    <= '0;
            hit_reg      <= '0;
            scan_idx_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mask_reg <= cfg_mask;
            end
            if (ctl.load_item)
            begin
                hit_reg      <= '0;
                scan_idx_reg <= '0;
                if (in_command == CMD_TICK)
                begin
                    time_reg <= time_reg + 1'b1;
                end
            end
            if (ctl.do_start)
            begin
                armed_reg[item_id_reg] <= 1'b1;
                if (item_mode_reg)
                begin
                    ring_reg <= ring_next;
                end
            end
            if (ctl.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_hit)
                begin
                    hit_reg[scan_idx_reg]   <= 1'b1;
                    armed_reg[scan_idx_reg] <= 1'b0;
                end
            end
            if (ctl.emit_expiry)
            begin
                hit_reg <= hit_rest;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_id_reg    <= in_timer_id;
            item_delay_reg <= in_delay_ticks;
            item_mode_reg  <= in_notify_mode;
        end
        if (ctl.do_start)
        begin
            deadline_mem[item_id_reg] <= time_reg + item_delay_reg;
            flow_mem[item_id_reg]     <= item_mode_reg;
            slot_mem[item_id_reg]     <= ring_reg;
            if (item_mode_reg)
            begin
                out_event_kind   <= EVT_STARTED;
                out_timer_number <= item_id_reg;
                out_uses_flow    <= 1'b1;
                out_flow_slot    <= ring_reg;
                out_last_of_run  <= 1'b1;
            end
        end
        if (ctl.emit_expiry)
        begin
            out_event_kind   <= EVT_EXPIRED;
            out_timer_number <= first_hit;
            out_uses_flow    <= flow_mem[first_hit];
            out_flow_slot    <= flow_mem[first_hit] ? slot_mem[first_hit] : '0;
            out_last_of_run  <= ~|hit_rest;
        end
    end

endmodule

`default_nettype wire

/* rtl/otdtb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module otdtb_ctrl import otdtb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire ctrl_sts_t sts,
    output ctrl_cmd_t      ctl
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       emit;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        emit       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                end
            end
            S_START:
            begin
                // A start without flow notification arms the timer silently.
                if (!sts.item_flow || out_free)
                begin
                    ctl.do_start = 1'b1;
                    emit         = sts.item_flow;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!sts.hits_any)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    ctl.emit_expiry = 1'b1;
                    emit            = 1'b1;
                    if (sts.hits_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (ctl.load_item)
        begin
            // The command field is not latched; route on the live value.
            state_next = sts.cmd_is_start ? S_START : S_SCAN;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/one_shot_delay_timer_bank.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bank of eight one-shot delay timers on a free-running tick count. A start item
// arms a timer with deadline = time + delay (mod 2^32); in flow mode it takes the
// next ring slot and yields one "started" result, otherwise it yields none. A
// tick item advances the time and then yields one "expired" result for every
// armed timer whose deadline is at or below the new time, lowest id first, the
// last of them marked last_of_run. A tick is handled by a scan that steps one
// shared deadline comparator over the eight timers; output stalls hold the
// start and emit states. The result register lets a new item be taken while
// the final result of the previous one still waits. The mask register may be
// written at any time the block is idle and takes effect on the next flow start.
module one_shot_delay_timer_bank import otdtb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    otdtb_cfg_if.sink   cfg,
    otdtb_in_if.sink    cmd,
    otdtb_out_if.source evt
);

    ctrl_cmd_t ctl;
    ctrl_sts_t sts;

    assign cfg.ready = 1'b1;

    otdtb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (evt.valid),
        .out_ready (evt.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    otdtb_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .sts              (sts),
        .cfg_we           (cfg.valid),
        .cfg_mask         (cfg.flow_slot_mask),
        .in_command       (cmd.command),
        .in_timer_id      (cmd.timer_id),
        .in_delay_ticks   (cmd.delay_ticks),
        .in_notify_mode   (cmd.notify_mode),
        .out_event_kind   (evt.event_kind),
        .out_timer_number (evt.timer_number),
        .out_uses_flow    (evt.uses_flow),
        .out_flow_slot    (evt.flow_slot),
        .out_last_of_run  (evt.last_of_run)
    );

endmodule

`default_nettype wire
